// ----- rtl/rlte_pkg.sv -----
// Shared types and constants for the run-length table engine.
package rlte_pkg;
    localparam int MaxRuns   = 64;
    localparam int CountBits = 16;
    localparam int RunIdxW   = $clog2(MaxRuns);
    localparam int RunCntW   = $clog2(MaxRuns + 1);
    localparam int LenW      = 16;
    localparam logic [LenW-1:0]      LenMax   = '1;
    localparam logic [CountBits-1:0] CountMax = '1;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_MERGE,
        S_DONE
    } state_t;

    // Row operation broadcast to every cell.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INC,
        OP_DEC,
        OP_LOAD,
        OP_PULL,
        OP_MERGE
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [RunIdxW-1:0]     sel;
        logic [7:0]             value;
        logic [CountBits-1:0]   count;
        logic [LenW:0]          base;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  value;
        logic [15:0] index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  byte_out;
        logic [15:0] total_length;
    } rsp_t;
endpackage

// ----- rtl/rlte_if.sv -----
// Valid/ready channel carrying one request or result.
interface rlte_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rlte_cell.sv -----
// One run slot: value, count, and the count of all bytes ahead of it.
module rlte_cell (
    input  logic                           clk,
    input  logic [rlte_pkg::RunIdxW-1:0]   pos,
    input  rlte_pkg::cell_ctl_t            ctl,
    input  logic [7:0]                     right_value,
    input  logic [rlte_pkg::CountBits-1:0] right_count,
    input  logic [rlte_pkg::LenW:0]        right_base,
    output logic [7:0]                     value,
    output logic [rlte_pkg::CountBits-1:0] count,
    output logic [rlte_pkg::LenW:0]        base
);
    import rlte_pkg::*;

    logic [7:0]           value_reg;
    logic [CountBits-1:0] count_reg;
    logic [LenW:0]        base_reg;
    logic                 hit;
    logic                 above;

    assign hit   = (ctl.sel == pos);
    assign above = (pos >= ctl.sel);

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_INC:
            begin
                if (hit)
                    count_reg <= count_reg + 1'b1;
                else if (above)
                    base_reg <= base_reg + 1'b1;
            end
            OP_DEC:
            begin
                if (hit)
                    count_reg <= count_reg - 1'b1;
                else if (above)
                    base_reg <= base_reg - 1'b1;
            end
            OP_LOAD:
            begin
                if (hit)
                begin
                    value_reg <= ctl.value;
                    count_reg <= ctl.count;
                    base_reg  <= ctl.base;
                end
            end
            OP_PULL:
            begin
                // dropped run held a single byte
                if (above)
                begin
                    value_reg <= right_value;
                    count_reg <= right_count;
                    base_reg  <= right_base - 1'b1;
                end
            end
            OP_MERGE:
            begin
                if (hit)
                    count_reg <= count_reg + right_count;
                else if (above)
                begin
                    value_reg <= right_value;
                    count_reg <= right_count;
                    base_reg  <= right_base;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign value = value_reg;
    assign count = count_reg;
    assign base  = base_reg;
endmodule

// ----- rtl/run_length_table_engine.sv -----
// Run-length table engine top level: control sequencer over a row of run cells.
// After a request is taken, its result passes through states: S_SCAN sets up the
// result, S_ACT has every cell compare its stored prefix count with the index and acts
// on the located cell, and S_DONE presents the result. Dropping a run adds one row
// shift (S_SHIFT), and merging its neighbors adds one more (S_MERGE). Each cell keeps
// its prefix count up to date with every table change, so no adder chain runs along the
// row. Requests are handled one at a time: a new request is taken only once the engine
// has returned to idle after presenting the previous result. A presented result waits
// in its own register while the next request runs; that request then stalls until the
// waiting result is taken.
module run_length_table_engine (
    input  logic clk,
    input  logic rst_n,
    rlte_if.sink   req,
    rlte_if.source rsp
);
    import rlte_pkg::*;

    state_t               state_reg, state_next;
    req_t                 cur_reg, cur_next;
    logic [RunCntW-1:0]   used_reg, used_next;
    logic [LenW-1:0]      len_reg, len_next;
    rsp_t                 res_reg, res_next;
    rsp_t                 out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RunIdxW-1:0]   loc_reg, loc_next;
    cell_ctl_t            ctl;

    logic [7:0]           cv   [MaxRuns];
    logic [CountBits-1:0] cc   [MaxRuns];
    logic [LenW:0]        cb   [MaxRuns];
    logic [MaxRuns-1:0]   hitv;

    genvar g;
    generate
        for (g = 0; g < MaxRuns; g++)
        begin : g_cell
            logic [7:0]           rv;
            logic [CountBits-1:0] rc;
            logic [LenW:0]        rb;
            if (g + 1 < MaxRuns)
            begin : g_r
                assign rv = cv[g+1];
                assign rc = cc[g+1];
                assign rb = cb[g+1];
            end
            else
            begin : g_e
                assign rv = '0;
                assign rc = '0;
                assign rb = '0;
            end
            rlte_cell u_cell (
                .clk         (clk),
                .pos         (RunIdxW'(g)),
                .ctl         (ctl),
                .right_value (rv),
                .right_count (rc),
                .right_base  (rb),
                .value       (cv[g]),
                .count       (cc[g]),
                .base        (cb[g])
            );
            // Cell holds index if it is valid and base <= idx < base + count.
            assign hitv[g] = (RunCntW'(g) < used_reg)
                && (17'(cur_reg.index) >= cb[g])
                && (17'(cur_reg.index) < cb[g] + 17'(cc[g]));
        end
    endgenerate

    logic [RunIdxW-1:0] hit_pos;
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < MaxRuns; i++)
        begin
            if (hitv[i])
                hit_pos = RunIdxW'(i);
        end
    end

    logic [RunIdxW-1:0] last;
    assign last = RunIdxW'(used_reg - 1'b1);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        out_reg <= out_next;
        loc_reg <= loc_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        len_next       = len_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        loc_next       = loc_reg;
        ctl.op         = OP_HOLD;
        ctl.sel        = '0;
        ctl.value      = cur_reg.value;
        ctl.count      = CountBits'(1);
        ctl.base       = {1'b0, len_reg};

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cur_next   = req.data;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                res_next.status       = ST_OK;
                res_next.byte_out     = '0;
                res_next.total_length = len_reg;
                state_next            = S_ACT;
            end
            S_ACT:
            begin
                state_next = S_DONE;
                case (cur_reg.mode)
                    MODE_APPEND:
                    begin
                        if (len_reg == LenMax)
                            res_next.status = ST_FULL;
                        else if (used_reg != '0 && cv[last] == cur_reg.value
                                 && cc[last] != CountMax)
                        begin
                            ctl.op   = OP_INC;
                            ctl.sel  = last;
                            len_next = len_reg + 1'b1;
                        end
                        else if (used_reg == RunCntW'(MaxRuns))
                            res_next.status = ST_FULL;
                        else
                        begin
                            ctl.op    = OP_LOAD;
                            ctl.sel   = RunIdxW'(used_reg);
                            used_next = used_reg + 1'b1;
                            len_next  = len_reg + 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (17'(cur_reg.index) >= 17'(len_reg) || used_reg == '0)
                            res_next.status = ST_INDEX;
                        else
                        begin
                            len_next = len_reg - 1'b1;
                            if (cc[hit_pos] > CountBits'(1))
                            begin
                                ctl.op  = OP_DEC;
                                ctl.sel = hit_pos;
                            end
                            else
                            begin
                                loc_next   = hit_pos;
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    MODE_GET:
                    begin
                        if (17'(cur_reg.index) >= 17'(len_reg) || used_reg == '0)
                            res_next.status = ST_INDEX;
                        else
                            res_next.byte_out = cv[hit_pos];
                    end
                    default:
                    begin
                    end
                endcase
                res_next.total_length = len_next;
            end
            S_SHIFT:
            begin
                ctl.op     = OP_PULL;
                ctl.sel    = loc_reg;
                used_next  = used_reg - 1'b1;
                // Merge check on pre-shift neighbors loc-1 and loc+1.
                if (loc_reg != '0 && (RunCntW'(loc_reg) + 1'b1) < used_reg
                    && cv[loc_reg - 1'b1] == cv[loc_reg + 1'b1]
                    && ({1'b0, cc[loc_reg - 1'b1]} + {1'b0, cc[loc_reg + 1'b1]})
                       <= {1'b0, CountMax})
                    state_next = S_MERGE;
                else
                    state_next = S_DONE;
            end
            S_MERGE:
            begin
                // Fold the run at loc into loc-1 and close the gap.
                ctl.op     = OP_MERGE;
                ctl.sel    = loc_reg - 1'b1;
                used_next  = used_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
